[rtl/fdcd_pkg.sv]
`timescale 1ns / 1ps
package fdcd_pkg;

	localparam int FRAME_PIXELS = 307200;
	localparam int PIX_W        = 8;
	localparam int TALLY_W      = 19;
	localparam int FRAME_NUM_W  = 16;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 19;
	localparam int ADDR_W       = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
	localparam int POS_W        = $clog2(FRAME_PIXELS + 1);
	localparam int CMP_W        = PIX_W + 2;

	localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

	localparam logic [PIX_W-1:0]   TOLERANCE_RST = 8'd8;
	localparam logic [PIX_W-1:0]   TOP_RST       = 8'd255;
	localparam logic [PIX_W-1:0]   BOTTOM_RST    = 8'd0;
	localparam logic [TALLY_W-1:0] LOW_LIM_RST   = 19'd0;
	localparam logic [TALLY_W-1:0] HIGH_LIM_RST  = 19'd307200;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PIXEL_TOLERANCE  = 3'd0,
		REG_PIXEL_TOP        = 3'd1,
		REG_PIXEL_BOTTOM     = 3'd2,
		REG_COUNT_LOW_LIMIT  = 3'd3,
		REG_COUNT_HIGH_LIMIT = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic [PIX_W-1:0] tolerance;
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] bottom;
	} pix_cfg_t;

endpackage

[rtl/fdcd_ram.sv]
`timescale 1ns / 1ps
module fdcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/fdcd_cmp.sv]
`timescale 1ns / 1ps
module fdcd_cmp (
	input  fdcd_pkg::pix_cfg_t                cfg,
	input  logic [fdcd_pkg::PIX_W-1:0]        old_pix,
	input  logic [fdcd_pkg::PIX_W-1:0]        new_pix,
	output logic                              differs
);

	logic signed [fdcd_pkg::CMP_W-1:0] o;
	logic signed [fdcd_pkg::CMP_W-1:0] n;
	logic signed [fdcd_pkg::CMP_W-1:0] t;
	logic signed [fdcd_pkg::CMP_W-1:0] top;
	logic signed [fdcd_pkg::CMP_W-1:0] bot;
	logic                              below;
	logic                              above;

	always_comb begin
		o     = signed'({2'b00, old_pix});
		n     = signed'({2'b00, new_pix});
		t     = signed'({2'b00, cfg.tolerance});
		top   = signed'({2'b00, cfg.top});
		bot   = signed'({2'b00, cfg.bottom});
		below = n < (o - t);
		above = n > (o + t);
		priority if (o >= (top - t)) begin
			differs = below;
		end else if (o <= (bot + t)) begin
			differs = above;
		end else begin
			differs = below | above;
		end
	end

endmodule

[rtl/frame_difference_change_detector.sv]
`timescale 1ns / 1ps
// A pixel beat accepted is registered into stage 1 as the frame store is read, and compared
// there; on the last pixel of a frame the result beat is registered when stage 1 advances.
// Throughput: one pixel per cycle unless a result beat is held while out_ready is low; the
// store is read at accept and written as stage 1 advances, with a bypass when both hit one entry.
// Reset: arst_n clears counters, the reference flag, valids and restores register defaults;
// the frame store is not cleared and the first frame only fills it.
module frame_difference_change_detector (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [fdcd_pkg::PIX_W-1:0]            pixel_value,
	input  logic                                  last_in_frame,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [fdcd_pkg::TALLY_W-1:0]          differing_pixels,
	output logic                                  change_detected,
	output logic [fdcd_pkg::FRAME_NUM_W-1:0]      frame_number,
	input  logic                                  cfg_write,
	input  logic [fdcd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fdcd_pkg::CFG_DATA_W-1:0]       cfg_data
);

	fdcd_pkg::pix_cfg_t                   pix_cfg_q;
	logic [fdcd_pkg::TALLY_W-1:0]         low_lim_q;
	logic [fdcd_pkg::TALLY_W-1:0]         high_lim_q;

	logic [fdcd_pkg::POS_W-1:0]           pos_q;
	logic                                 have_ref_q;
	logic [fdcd_pkg::FRAME_NUM_W-1:0]     frame_q;
	logic [fdcd_pkg::TALLY_W-1:0]         tally_q;

	logic                                 valid_s1;
	logic [fdcd_pkg::PIX_W-1:0]           pix_s1;
	logic                                 last_s1;
	logic                                 inr_s1;
	logic                                 hr_s1;
	logic                                 fwd_s1;
	logic [fdcd_pkg::PIX_W-1:0]           fwd_pix_s1;
	logic [fdcd_pkg::ADDR_W-1:0]          addr_s1;
	logic [fdcd_pkg::FRAME_NUM_W-1:0]     fn_s1;

	logic                                 out_valid_q;
	logic [fdcd_pkg::TALLY_W-1:0]         count_q;
	logic                                 change_q;
	logic [fdcd_pkg::FRAME_NUM_W-1:0]     fnum_q;

	logic                                 advance;
	logic                                 accept;
	logic                                 in_range;
	logic [fdcd_pkg::ADDR_W-1:0]          rd_addr;
	logic                                 s1_fire;
	logic                                 wr_en;
	logic                                 fwd;
	logic [fdcd_pkg::PIX_W-1:0]           ram_rdata;
	logic [fdcd_pkg::PIX_W-1:0]           old_pix;
	logic                                 differs;
	logic                                 hit;
	logic [fdcd_pkg::TALLY_W-1:0]         tally_sum;
	logic                                 in_window;

	assign advance  = ~out_valid_q | out_ready;
	assign in_ready = advance;
	assign accept   = in_valid & advance;
	assign in_range = pos_q < fdcd_pkg::POS_W'(fdcd_pkg::FRAME_PIXELS);
	assign rd_addr  = pos_q[fdcd_pkg::ADDR_W-1:0];
	assign s1_fire  = valid_s1 & advance;
	assign wr_en    = s1_fire & inr_s1;
	assign fwd      = wr_en && (addr_s1 == rd_addr);

	fdcd_ram #(
		.WIDTH (fdcd_pkg::PIX_W),
		.DEPTH (fdcd_pkg::FRAME_PIXELS)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (pix_s1),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	assign old_pix = fwd_s1 ? fwd_pix_s1 : ram_rdata;

	fdcd_cmp u_cmp (
		.cfg     (pix_cfg_q),
		.old_pix (old_pix),
		.new_pix (pix_s1),
		.differs (differs)
	);

	assign hit       = hr_s1 & inr_s1 & differs;
	assign tally_sum = (hit && (tally_q != fdcd_pkg::TALLY_MAX)) ?
		tally_q + fdcd_pkg::TALLY_W'(1) : tally_q;
	assign in_window = (tally_sum >= low_lim_q) && (tally_sum <= high_lim_q);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_cfg_q.tolerance <= fdcd_pkg::TOLERANCE_RST;
			pix_cfg_q.top       <= fdcd_pkg::TOP_RST;
			pix_cfg_q.bottom    <= fdcd_pkg::BOTTOM_RST;
			low_lim_q           <= fdcd_pkg::LOW_LIM_RST;
			high_lim_q          <= fdcd_pkg::HIGH_LIM_RST;
		end else if (cfg_write) begin
			unique case (fdcd_pkg::reg_index_t'(cfg_index))
				fdcd_pkg::REG_PIXEL_TOLERANCE: begin
					pix_cfg_q.tolerance <= cfg_data[fdcd_pkg::PIX_W-1:0];
				end
				fdcd_pkg::REG_PIXEL_TOP: begin
					pix_cfg_q.top <= cfg_data[fdcd_pkg::PIX_W-1:0];
				end
				fdcd_pkg::REG_PIXEL_BOTTOM: begin
					pix_cfg_q.bottom <= cfg_data[fdcd_pkg::PIX_W-1:0];
				end
				fdcd_pkg::REG_COUNT_LOW_LIMIT: begin
					low_lim_q <= cfg_data[fdcd_pkg::TALLY_W-1:0];
				end
				fdcd_pkg::REG_COUNT_HIGH_LIMIT: begin
					high_lim_q <= cfg_data[fdcd_pkg::TALLY_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// input side: position, frame bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			have_ref_q <= 1'b0;
			frame_q    <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (last_in_frame) begin
					pos_q      <= '0;
					have_ref_q <= 1'b1;
					frame_q    <= frame_q + fdcd_pkg::FRAME_NUM_W'(1);
				end else if (in_range) begin
					pos_q <= pos_q + fdcd_pkg::POS_W'(1);
				end
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1     <= pixel_value;
			last_s1    <= last_in_frame;
			inr_s1     <= in_range;
			hr_s1      <= have_ref_q;
			fwd_s1     <= fwd;
			fwd_pix_s1 <= pix_s1;
			addr_s1    <= rd_addr;
			fn_s1      <= frame_q;
		end
	end

	// compare stage: tally and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_fire) begin
				tally_q <= last_s1 ? '0 : tally_sum;
			end
			if (s1_fire && last_s1 && hr_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1 && hr_s1) begin
			count_q  <= tally_sum;
			change_q <= in_window;
			fnum_q   <= fn_s1;
		end
	end

	assign out_valid        = out_valid_q;
	assign differing_pixels = count_q;
	assign change_detected  = change_q;
	assign frame_number     = fnum_q;

endmodule

[bench/frame_difference_change_detector_tb.sv]
`timescale 1ns / 1ps
module frame_difference_change_detector_tb;

	localparam int IDLE_PCT     = 37;
	localparam int MAX_SHOWN    = 10;
	localparam int NEAR_DEPTH   = 64;
	localparam int PHASE_ITEMS  = 185;
	localparam int BURST_FRAMES = 32;

	typedef struct packed {
		logic [fdcd_pkg::PIX_W-1:0] luma;
		logic                       last;
	} pixel_beat_t;

	typedef struct packed {
		logic [fdcd_pkg::TALLY_W-1:0]     count;
		logic                             changed;
		logic [fdcd_pkg::FRAME_NUM_W-1:0] frame;
	} frame_report_t;

	logic                             clk;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_ready;
	logic [fdcd_pkg::PIX_W-1:0]       pixel_value = '0;
	logic                             last_in_frame = 1'b0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic [fdcd_pkg::TALLY_W-1:0]     differing_pixels;
	logic                             change_detected;
	logic [fdcd_pkg::FRAME_NUM_W-1:0] frame_number;
	logic                             cfg_write = 1'b0;
	logic [fdcd_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [fdcd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

	logic in_took = 1'b0;
	int   in_idle_pct = IDLE_PCT;
	int   out_idle_pct = IDLE_PCT;
	int   mismatches = 0;

	pixel_beat_t   pending_pixels[$];
	frame_report_t expected_reports[$];

	// register shadow
	logic [fdcd_pkg::PIX_W-1:0]   tol_set = fdcd_pkg::TOLERANCE_RST;
	logic [fdcd_pkg::PIX_W-1:0]   top_set = fdcd_pkg::TOP_RST;
	logic [fdcd_pkg::PIX_W-1:0]   bottom_set = fdcd_pkg::BOTTOM_RST;
	logic [fdcd_pkg::TALLY_W-1:0] low_set = fdcd_pkg::LOW_LIM_RST;
	logic [fdcd_pkg::TALLY_W-1:0] high_set = fdcd_pkg::HIGH_LIM_RST;

	// change predictor state
	logic [fdcd_pkg::PIX_W-1:0]       prior_luma [fdcd_pkg::FRAME_PIXELS];
	int                               scan_pos = 0;
	int                               diff_count = 0;
	bit                               primed = 1'b0;
	logic [fdcd_pkg::FRAME_NUM_W-1:0] frames_seen = '0;

	// generator-side copy of the first store entries, for near-tolerance stimulus
	logic [fdcd_pkg::PIX_W-1:0] near_luma [NEAR_DEPTH];
	int                         gen_pos = 0;

	frame_difference_change_detector dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.pixel_value      (pixel_value),
		.last_in_frame    (last_in_frame),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.differing_pixels (differing_pixels),
		.change_detected  (change_detected),
		.frame_number     (frame_number),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#(64'd20_000_000);
		$display("tb: failure");
		$finish;
	end

	function automatic bit luma_changed(int o, int n);
		int t;
		t = int'(tol_set);
		if (o >= int'(top_set) - t)
			return n < o - t;
		if (o <= int'(bottom_set) + t)
			return n > o + t;
		return (n < o - t) || (n > o + t);
	endfunction

	function automatic void track_pixel(pixel_beat_t b);
		frame_report_t r;
		if (scan_pos < fdcd_pkg::FRAME_PIXELS) begin
			if (primed && luma_changed(int'(prior_luma[scan_pos]), int'(b.luma)) &&
			    diff_count < int'(fdcd_pkg::TALLY_MAX))
				diff_count++;
			prior_luma[scan_pos] = b.luma;
			scan_pos++;
		end
		if (b.last) begin
			if (primed) begin
				r.count   = fdcd_pkg::TALLY_W'(diff_count);
				r.changed = (fdcd_pkg::TALLY_W'(diff_count) >= low_set) &&
					(fdcd_pkg::TALLY_W'(diff_count) <= high_set);
				r.frame   = frames_seen;
				expected_reports.push_back(r);
			end
			primed      = 1'b1;
			frames_seen = frames_seen + 1'b1;
			scan_pos    = 0;
			diff_count  = 0;
		end
	endfunction

	function automatic logic [fdcd_pkg::PIX_W-1:0] luma_clamp(int x);
		if (x < 0)
			return '0;
		if (x > 255)
			return '1;
		return fdcd_pkg::PIX_W'(x);
	endfunction

	always @(negedge clk) begin
		pixel_beat_t beat;
		if (arst_n && (!in_valid || in_took)) begin
			if (pending_pixels.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
				beat = pending_pixels.pop_front();
				in_valid      <= 1'b1;
				pixel_value   <= beat.luma;
				last_in_frame <= beat.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= arst_n && ($urandom_range(99) >= out_idle_pct);
	end

	always @(posedge clk) begin
		pixel_beat_t   seen;
		frame_report_t got;
		frame_report_t want;
		in_took <= arst_n && in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				seen.luma = pixel_value;
				seen.last = last_in_frame;
				track_pixel(seen);
			end
			if (out_valid && out_ready) begin
				got.count   = differing_pixels;
				got.changed = change_detected;
				got.frame   = frame_number;
				if (expected_reports.size() == 0) begin
					if (mismatches < MAX_SHOWN)
						$display("unexpected report beat: count %0d change %0b frame %0d",
							got.count, got.changed, got.frame);
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					if (got !== want) begin
						if (mismatches < MAX_SHOWN)
							$display({"report mismatch: expected count %0d change %0b frame %0d,",
								" got count %0d change %0b frame %0d"},
								want.count, want.changed, want.frame,
								got.count, got.changed, got.frame);
						mismatches++;
					end
				end
			end
		end
	end

	task automatic push_pixel(input logic [fdcd_pkg::PIX_W-1:0] v, input bit eof);
		pixel_beat_t b;
		b.luma = v;
		b.last = eof;
		pending_pixels.push_back(b);
		if (gen_pos < NEAR_DEPTH)
			near_luma[gen_pos] = v;
		if (gen_pos < fdcd_pkg::FRAME_PIXELS)
			gen_pos++;
		if (eof)
			gen_pos = 0;
	endtask

	task automatic write_reg(input logic [fdcd_pkg::CFG_IDX_W-1:0] idx,
			input logic [fdcd_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
		fdcd_pkg::REG_PIXEL_TOLERANCE:  tol_set = val[fdcd_pkg::PIX_W-1:0];
		fdcd_pkg::REG_PIXEL_TOP:        top_set = val[fdcd_pkg::PIX_W-1:0];
		fdcd_pkg::REG_PIXEL_BOTTOM:     bottom_set = val[fdcd_pkg::PIX_W-1:0];
		fdcd_pkg::REG_COUNT_LOW_LIMIT:  low_set = val[fdcd_pkg::TALLY_W-1:0];
		fdcd_pkg::REG_COUNT_HIGH_LIMIT: high_set = val[fdcd_pkg::TALLY_W-1:0];
		default: ;
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic apply_settings(input logic [fdcd_pkg::PIX_W-1:0] tol,
			input logic [fdcd_pkg::PIX_W-1:0] top,
			input logic [fdcd_pkg::PIX_W-1:0] bottom,
			input logic [fdcd_pkg::TALLY_W-1:0] low,
			input logic [fdcd_pkg::TALLY_W-1:0] high);
		write_reg(fdcd_pkg::REG_PIXEL_TOLERANCE, fdcd_pkg::CFG_DATA_W'(tol));
		write_reg(fdcd_pkg::REG_PIXEL_TOP, fdcd_pkg::CFG_DATA_W'(top));
		write_reg(fdcd_pkg::REG_PIXEL_BOTTOM, fdcd_pkg::CFG_DATA_W'(bottom));
		write_reg(fdcd_pkg::REG_COUNT_LOW_LIMIT, fdcd_pkg::CFG_DATA_W'(low));
		write_reg(fdcd_pkg::REG_COUNT_HIGH_LIMIT, fdcd_pkg::CFG_DATA_W'(high));
	endtask

	// wait until the block has taken every pixel and delivered every report
	task automatic settle();
		while (pending_pixels.size() != 0 || in_valid || expected_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic random_frames(input int n_items);
		int                         len;
		int                         k;
		int                         o;
		int                         d;
		logic [fdcd_pkg::PIX_W-1:0] v;
		while (n_items > 0) begin
			case ($urandom_range(9))
			0:       len = 1;
			1:       len = $urandom_range(NEAR_DEPTH / 2 + 1, NEAR_DEPTH);
			default: len = $urandom_range(2, 24);
			endcase
			for (k = 0; k < len; k++) begin
				o = int'(near_luma[gen_pos]);
				case ($urandom_range(9))
				0, 1, 2: v = fdcd_pkg::PIX_W'($urandom);
				3:       v = ($urandom_range(1) != 0) ? '1 : '0;
				4: begin
					d = int'(tol_set) + 1 - int'($urandom_range(1));
					if ($urandom_range(1) != 0)
						d = -d;
					v = luma_clamp(o + d);
				end
				default: v = luma_clamp(o + int'($urandom_range(2 * tol_set + 4)) -
					int'(tol_set) - 2);
				endcase
				push_pixel(v, k == len - 1);
			end
			n_items -= len;
		end
	endtask

	task automatic run_phase(input logic [fdcd_pkg::PIX_W-1:0] tol,
			input logic [fdcd_pkg::PIX_W-1:0] top,
			input logic [fdcd_pkg::PIX_W-1:0] bottom,
			input logic [fdcd_pkg::TALLY_W-1:0] low,
			input logic [fdcd_pkg::TALLY_W-1:0] high);
		apply_settings(tol, top, bottom, low, high);
		random_frames(PHASE_ITEMS);
		settle();
	endtask

	task automatic run_random_phase();
		logic [fdcd_pkg::TALLY_W-1:0] low;
		low = fdcd_pkg::TALLY_W'($urandom_range(16));
		run_phase(fdcd_pkg::PIX_W'($urandom_range(24)), fdcd_pkg::PIX_W'($urandom),
			fdcd_pkg::PIX_W'($urandom), low,
			low + fdcd_pkg::TALLY_W'($urandom_range(24)) -
			fdcd_pkg::TALLY_W'($urandom_range(1)));
	endtask

	initial begin
		int seed_luma;
		int k;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fill every store entry that later frames reach, then a frame of the same
		// length that differs everywhere, with the window pinned at that count
		in_idle_pct = 0;
		apply_settings(fdcd_pkg::TOLERANCE_RST, fdcd_pkg::TOP_RST, fdcd_pkg::BOTTOM_RST,
			fdcd_pkg::TALLY_W'(NEAR_DEPTH), fdcd_pkg::TALLY_W'(NEAR_DEPTH));
		seed_luma = $urandom_range(255);
		for (k = 0; k < NEAR_DEPTH; k++)
			push_pixel(fdcd_pkg::PIX_W'(k * 37 + seed_luma), k == NEAR_DEPTH - 1);
		for (k = 0; k < NEAR_DEPTH; k++)
			push_pixel(fdcd_pkg::PIX_W'(k * 37 + seed_luma) ^ 8'h80, k == NEAR_DEPTH - 1);
		settle();
		in_idle_pct = IDLE_PCT;

		// tolerance edges near bottom, top and mid range
		apply_settings(fdcd_pkg::TOLERANCE_RST, fdcd_pkg::TOP_RST, fdcd_pkg::BOTTOM_RST,
			fdcd_pkg::LOW_LIM_RST, fdcd_pkg::HIGH_LIM_RST);
		push_pixel(8'd0, 1'b0); push_pixel(8'd255, 1'b0); push_pixel(8'd128, 1'b0);
		push_pixel(8'd128, 1'b0); push_pixel(8'd10, 1'b0); push_pixel(8'd250, 1'b1);
		push_pixel(8'd9, 1'b0); push_pixel(8'd246, 1'b0); push_pixel(8'd137, 1'b0);
		push_pixel(8'd119, 1'b0); push_pixel(8'd0, 1'b0); push_pixel(8'd255, 1'b1);
		push_pixel(8'd8, 1'b0); push_pixel(8'd255, 1'b1);
		settle();
		// empty count window
		write_reg(fdcd_pkg::REG_COUNT_LOW_LIMIT, fdcd_pkg::CFG_DATA_W'(2));
		write_reg(fdcd_pkg::REG_COUNT_HIGH_LIMIT, fdcd_pkg::CFG_DATA_W'(1));
		push_pixel(8'd0, 1'b0); push_pixel(8'd247, 1'b1);
		settle();
		write_reg(fdcd_pkg::REG_PIXEL_TOLERANCE, '0);
		push_pixel(8'd0, 1'b0); push_pixel(8'd248, 1'b1);
		push_pixel(8'd1, 1'b1);
		settle();

		run_phase(8'd0, 8'd255, 8'd0, 19'd1, 19'd10);
		run_phase(8'd255, 8'd0, 8'd255, 19'd0, 19'd0);
		for (k = int'(fdcd_pkg::REG_COUNT_HIGH_LIMIT) + 1; k < 2 ** fdcd_pkg::CFG_IDX_W; k++)
			write_reg(fdcd_pkg::CFG_IDX_W'(k), fdcd_pkg::CFG_DATA_W'($urandom));
		run_phase(8'd20, 8'd200, 8'd60, 19'd12, 19'd3);

		// single-pixel frames back to back
		apply_settings(fdcd_pkg::PIX_W'($urandom_range(24)), fdcd_pkg::PIX_W'($urandom),
			fdcd_pkg::PIX_W'($urandom), fdcd_pkg::TALLY_W'($urandom_range(1)),
			fdcd_pkg::TALLY_W'($urandom_range(1)));
		repeat (BURST_FRAMES) push_pixel(fdcd_pkg::PIX_W'($urandom), 1'b1);
		settle();

		in_idle_pct  = 0;
		out_idle_pct = 0;
		run_random_phase();
		in_idle_pct  = IDLE_PCT;
		out_idle_pct = IDLE_PCT;
		run_phase(8'd3, 8'd128, 8'd128, 19'd0, fdcd_pkg::HIGH_LIM_RST);
		repeat (2) run_random_phase();

		repeat (16) @(posedge clk);
		if (mismatches == 0 && expected_reports.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
